// File: rtl/core/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg: shared types, constants and helpers of the attitude filter
// item layouts, register map, controller encodings and fixed-point helpers
// ----------------------------------------------------------------------------
package icf_pkg;

  // moving mean and cordic depth
  localparam int WINDOW_LEN   = 5;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_EFF   = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int ITER_W       = 5;
  localparam int POS_W        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int WIN_DEPTH    = 3 * WINDOW_LEN;
  localparam int IDX_W        = $clog2(WIN_DEPTH);
  localparam int SUM_W        = 25 + $clog2(WINDOW_LEN);

  // reciprocal of the window length, 32 fractional bits, rounded up
  localparam longint WIN_RECIP_L = ((64'd1 << 32) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [32:0] WIN_RECIP = 33'(WIN_RECIP_L);
  // reciprocal of 131, 30 fractional bits, rounded up (rate = raw*128/131)
  localparam logic [23:0] SCALE_RECIP = 24'd8196503;
  localparam int SQRT_STEPS = 16;

  localparam logic signed [31:0] WRAP_LIMIT = 32'sd23040;

  // register map
  typedef enum logic [2:0] {
    REG_DEADZONE = 3'd0,
    REG_OUTLIER  = 3'd1,
    REG_STEP     = 3'd2,
    REG_WEIGHT   = 3'd3,
    REG_ROLL_OFF = 3'd4,
    REG_PITCH_OFF = 3'd5,
    REG_CALIB    = 3'd6
  } reg_idx_t;

  // input operation codes
  localparam logic OPER_SAMPLE = 1'b0;
  localparam logic OPER_RECAL  = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        deadzone_rate;
    logic [19:0]        outlier_limit;
    logic [15:0]        integration_step;
    logic [15:0]        gyro_weight;
    logic signed [15:0] roll_offset;
    logic signed [15:0] pitch_offset;
    logic [7:0]         calib_samples;
  } cfg_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCALE,
    OP_BIAS,
    OP_WIN,
    OP_DIV,
    OP_MEAN,
    OP_RECAL,
    OP_CLEAR,
    OP_BIASCNT,
    OP_SQA,
    OP_SQB,
    OP_SQRT,
    OP_CINIT,
    OP_CORDIC,
    OP_TILT,
    OP_IMUL,
    OP_IACC,
    OP_BMUL1,
    OP_BMUL2,
    OP_BLEND,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       tilt;
  } cmd_t;

  typedef struct packed {
    logic cordic_zero;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECAL,
    ST_CLEAR,
    ST_AXIS,
    ST_BIASCNT,
    ST_SQA,
    ST_SQB,
    ST_SQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_TILT,
    ST_INTEG,
    ST_OUT
  } ctrl_state_t;

  // atan(2^-i) in degrees, 16 fractional bits
  function automatic logic [21:0] atan_q16(input logic [ITER_W-1:0] i);
    logic [21:0] v;
    begin
      case (i)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction

  // saturate to 24 bits signed
  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    logic signed [23:0] r;
    begin
      if (v > 32'sd8388607) r = 24'sh7FFFFF;
      else if (v < -32'sd8388608) r = 24'sh800000;
      else r = v[23:0];
      return r;
    end
  endfunction

  // single wrap by 360 degrees then saturate to 16 bits
  function automatic logic signed [15:0] wrap16(input logic signed [31:0] v);
    logic signed [31:0] t;
    logic signed [15:0] r;
    begin
      t = v;
      if (t > WRAP_LIMIT) t = t - WRAP_LIMIT;
      else if (t < -WRAP_LIMIT) t = t + WRAP_LIMIT;
      if (t > 32'sd32767) r = 16'sh7FFF;
      else if (t < -32'sd32768) r = 16'sh8000;
      else r = t[15:0];
      return r;
    end
  endfunction

endpackage

// File: rtl/core/imu_attitude_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// imu_attitude_complementary_filter_top: six-axis attitude filter
// roll, pitch and yaw from raw gyro and accelerometer samples
// ----------------------------------------------------------------------------
// One request at a time. A sample request runs through the rate work (five
// steps per gyro axis plus a bookkeeping step), then for each of the two tilt
// angles the squares, the 16-step square root, the cordic set-up, 1 to 16
// cordic steps (fewer when the vector reaches the axis early) and the angle
// step, then integration and blending, and last a load of the output register.
// A recalibrate request returns zero angles. The finished result sits in an
// output register, so it may wait for the consumer while the next request is
// already being worked on; a further result then waits, and input is held
// off, until that register is taken.
// ----------------------------------------------------------------------------
module imu_attitude_complementary_filter_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  icf_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output icf_pkg::out_item_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import icf_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t status;

  // configuration registers
  icf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  icf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_oper   (in_data.operation),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  icf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data),
    .status   (status)
  );

endmodule

// File: rtl/core/icf_regs.sv
// ----------------------------------------------------------------------------
// icf_regs: configuration register file
// apb-style write and read of the seven filter settings
// ----------------------------------------------------------------------------
module icf_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output icf_pkg::cfg_t cfg
);
  import icf_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadzone_rate    <= 16'd256;
      cfg_r.outlier_limit    <= 20'd320000;
      cfg_r.integration_step <= 16'd983;
      cfg_r.gyro_weight      <= 16'd29491;
      cfg_r.roll_offset      <= -16'sd37;
      cfg_r.pitch_offset     <= 16'sd101;
      cfg_r.calib_samples    <= 8'd25;
    end else if (wr_en) begin
      case (idx)
        REG_DEADZONE:  cfg_r.deadzone_rate    <= pwdata[15:0];
        REG_OUTLIER:   cfg_r.outlier_limit    <= pwdata[19:0];
        REG_STEP:      cfg_r.integration_step <= pwdata[15:0];
        REG_WEIGHT:    cfg_r.gyro_weight      <= pwdata[15:0];
        REG_ROLL_OFF:  cfg_r.roll_offset      <= pwdata[15:0];
        REG_PITCH_OFF: cfg_r.pitch_offset     <= pwdata[15:0];
        REG_CALIB:     cfg_r.calib_samples    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (idx)
      REG_DEADZONE:  prdata = {16'd0, cfg_r.deadzone_rate};
      REG_OUTLIER:   prdata = {12'd0, cfg_r.outlier_limit};
      REG_STEP:      prdata = {16'd0, cfg_r.integration_step};
      REG_WEIGHT:    prdata = {16'd0, cfg_r.gyro_weight};
      REG_ROLL_OFF:  prdata = {{16{cfg_r.roll_offset[15]}}, cfg_r.roll_offset};
      REG_PITCH_OFF: prdata = {{16{cfg_r.pitch_offset[15]}}, cfg_r.pitch_offset};
      REG_CALIB:     prdata = {24'd0, cfg_r.calib_samples};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/icf_ctrl.sv
// ----------------------------------------------------------------------------
// icf_ctrl: sequencing state machine of the attitude filter
// steps the datapath through rate, tilt and integration work, or recalibration, for one request
// ----------------------------------------------------------------------------
module icf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_oper,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  icf_pkg::dp_status_t status,
  output icf_pkg::cmd_t       cmd
);
  import icf_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic              tilt_r, tilt_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sub_r       <= '0;
      axis_r      <= '0;
      tilt_r      <= 1'b0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      axis_r      <= axis_nxt;
      tilt_r      <= tilt_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sub_nxt   = sub_r;
    axis_nxt  = axis_r;
    tilt_nxt  = tilt_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        sub_nxt  = '0;
        axis_nxt = '0;
        tilt_nxt = 1'b0;
        iter_nxt = '0;
        if (in_valid) state_nxt = (in_oper == OPER_RECAL) ? ST_RECAL : ST_AXIS;
      end
      ST_RECAL: begin
        if (sub_r == 3'd1) begin
          sub_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = ST_CLEAR;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_CLEAR: state_nxt = ST_OUT;
      ST_AXIS: begin
        if (sub_r == 3'd4) begin
          sub_nxt = '0;
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = ST_BIASCNT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_BIASCNT: state_nxt = ST_SQA;
      ST_SQA:     state_nxt = ST_SQB;
      ST_SQB: begin
        iter_nxt  = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (iter_r == ITER_W'(SQRT_STEPS - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_CINIT;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_CINIT: begin
        iter_nxt  = '0;
        state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (status.cordic_zero || iter_r == ITER_W'(CORDIC_EFF - 1)) begin
          iter_nxt  = '0;
          state_nxt = ST_TILT;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      ST_TILT: begin
        if (!tilt_r) begin
          tilt_nxt  = 1'b1;
          state_nxt = ST_SQA;
        end else begin
          sub_nxt   = '0;
          axis_nxt  = '0;
          state_nxt = ST_INTEG;
        end
      end
      ST_INTEG: begin
        if ((axis_r == 2'd2 && sub_r == 3'd1) || sub_r == 3'd4) begin
          sub_nxt = '0;
          if (axis_r == 2'd2) begin
            state_nxt = ST_OUT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd.op   = OP_NONE;
    cmd.axis = axis_r;
    cmd.tilt = tilt_r;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_RECAL:   cmd.op = (sub_r == 3'd0) ? OP_DIV : OP_RECAL;
      ST_CLEAR:   cmd.op = OP_CLEAR;
      ST_AXIS: begin
        case (sub_r)
          3'd0:    cmd.op = OP_SCALE;
          3'd1:    cmd.op = OP_BIAS;
          3'd2:    cmd.op = OP_WIN;
          3'd3:    cmd.op = OP_DIV;
          default: cmd.op = OP_MEAN;
        endcase
      end
      ST_BIASCNT: cmd.op = OP_BIASCNT;
      ST_SQA:     cmd.op = OP_SQA;
      ST_SQB:     cmd.op = OP_SQB;
      ST_SQRT:    cmd.op = OP_SQRT;
      ST_CINIT:   cmd.op = OP_CINIT;
      ST_CORDIC:  cmd.op = OP_CORDIC;
      ST_TILT:    cmd.op = OP_TILT;
      ST_INTEG: begin
        case (sub_r)
          3'd0:    cmd.op = OP_IMUL;
          3'd1:    cmd.op = OP_IACC;
          3'd2:    cmd.op = OP_BMUL1;
          3'd3:    cmd.op = OP_BMUL2;
          default: cmd.op = OP_BLEND;
        endcase
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op   = OP_OUT;
          out_load = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  // result valid flag
  always_comb begin
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/icf_dp.sv
// ----------------------------------------------------------------------------
// icf_dp: datapath of the attitude filter
// filter state, shared multiplier steps, iterative square root and cordic
// ----------------------------------------------------------------------------
module icf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  icf_pkg::cmd_t        cmd,
  input  icf_pkg::cfg_t        cfg,
  input  icf_pkg::in_item_t    in_data,
  output icf_pkg::out_item_t   out_data,
  output icf_pkg::dp_status_t  status
);
  import icf_pkg::*;

  // filter state
  logic signed [23:0]      bias_r [3];
  logic                    seeded_r;
  logic [7:0]              bias_count_r;
  logic signed [23:0]      win_r [WIN_DEPTH];
  logic [POS_W-1:0]        pos_r;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [23:0]      gang_r [2];
  logic signed [15:0]      att_r [3];

  // working registers
  in_item_t                item_r;
  logic [63:0]             mul_r;
  logic                    neg_r;
  logic signed [17:0]      rate_r;
  logic signed [23:0]      mean_r [3];
  logic [31:0]             sq_r;
  logic [31:0]             rem_r;
  logic [31:0]             root_r;
  logic [31:0]             bit_r;
  logic signed [27:0]      cx_r, cy_r;
  logic signed [24:0]      cz_r;
  logic [ITER_W-1:0]       it_r;
  logic signed [17:0]      acc_r [2];
  logic signed [41:0]      dp_r;
  logic signed [43:0]      bp_r;
  out_item_t               out_r;

  // operand selection
  logic signed [15:0]      raw;
  logic [16:0]             raw_mag;
  logic [23:0]             scale_num;
  logic [16:0]             rate_mag;
  logic signed [17:0]      rate;
  logic                    averaging;
  logic signed [24:0]      bsum;
  logic signed [24:0]      bdiff;
  logic signed [23:0]      corr;
  logic [IDX_W-1:0]        idx;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        wq_mag;
  logic signed [SUM_W:0]   wq_s;
  logic signed [23:0]      wq;
  logic signed [16:0]      t_num;
  logic signed [15:0]      t_a;
  logic signed [15:0]      t_b;
  logic signed [31:0]      a_sq;
  logic signed [31:0]      b_sq;
  logic [31:0]             trial;
  logic signed [27:0]      sh_x, sh_y;
  logic [21:0]             ang;
  logic signed [24:0]      z_rnd;
  logic signed [15:0]      off;
  logic signed [23:0]      mean_sel;
  logic [3:0]              active;
  logic signed [40:0]      imul;
  logic signed [25:0]      dlt;
  logic [16:0]             w_cl;
  logic signed [17:0]      w_s;
  logic signed [17:0]      wi_s;
  logic signed [41:0]      p1;
  logic signed [35:0]      p2;
  logic signed [17:0]      acc_sel;
  logic signed [23:0]      gang_sel;

  // gyro rate selection and scaling by 128/131
  always_comb begin
    case (cmd.axis)
      2'd0:    raw = item_r.gyro_x;
      2'd1:    raw = item_r.gyro_y;
      default: raw = item_r.gyro_z;
    endcase
    raw_mag   = raw[15] ? 17'(-{raw[15], raw}) : {1'b0, raw};
    scale_num = {raw_mag, 7'd0} + 24'd65;
    rate_mag  = mul_r[46:30];
    rate      = neg_r ? -$signed({1'b0, rate_mag}) : $signed({1'b0, rate_mag});
  end

  // bias and window arithmetic
  always_comb begin
    averaging = bias_count_r < cfg.calib_samples;
    bsum      = 25'(bias_r[cmd.axis]) + 25'(rate);
    bdiff     = 25'(rate_r) - 25'(bias_r[cmd.axis]);
    corr      = sat24(32'(bdiff));
    idx       = IDX_W'(cmd.axis) * IDX_W'(WINDOW_LEN) + IDX_W'(pos_r);
    sum_sel   = sum_r[cmd.axis];
    sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    wq_mag    = mul_r[32 +: SUM_W];
    wq_s      = neg_r ? -$signed({1'b0, wq_mag}) : $signed({1'b0, wq_mag});
    wq        = wq_s[23:0];
  end

  // tilt operands: roll uses ay over (ax, az), pitch uses -ax over (ay, az)
  always_comb begin
    if (!cmd.tilt) begin
      t_num = 17'(item_r.accel_y);
      t_a   = item_r.accel_x;
      off   = cfg.roll_offset;
    end else begin
      t_num = -17'(item_r.accel_x);
      t_a   = item_r.accel_y;
      off   = cfg.pitch_offset;
    end
    t_b   = item_r.accel_z;
    a_sq  = t_a * t_a;
    b_sq  = t_b * t_b;
    trial = root_r + bit_r;
    sh_x  = cx_r >>> it_r;
    sh_y  = cy_r >>> it_r;
    ang   = atan_q16(it_r);
    z_rnd = (cz_r + 25'sd512) >>> 10;
  end

  // integration and blend operands
  always_comb begin
    mean_sel = mean_r[cmd.axis];
    for (int a = 0; a < 3; a++) begin
      active[a] = (mean_r[a][23] ? 24'(-mean_r[a]) : 24'(mean_r[a])) >
                  {8'd0, cfg.deadzone_rate};
    end
    active[3] = 1'b0;
    imul     = mean_sel * $signed({1'b0, cfg.integration_step});
    dlt      = dp_r[41:16];
    w_cl     = (cfg.gyro_weight > 16'd32768) ? 17'd32768 : {1'b0, cfg.gyro_weight};
    w_s      = $signed({1'b0, w_cl});
    wi_s     = $signed({1'b0, 17'd32768 - w_cl});
    acc_sel  = acc_r[cmd.axis[0]];
    gang_sel = gang_r[cmd.axis[0]];
    p1       = w_s * gang_sel;
    p2       = wi_s * acc_sel;
  end

  // control state of the filter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seeded_r     <= 1'b0;
      bias_count_r <= '0;
      pos_r        <= '0;
      for (int a = 0; a < 3; a++) begin
        bias_r[a] <= '0;
        sum_r[a]  <= '0;
        att_r[a]  <= '0;
      end
      for (int k = 0; k < WIN_DEPTH; k++) win_r[k] <= '0;
      gang_r[0] <= '0;
      gang_r[1] <= '0;
    end else begin
      case (cmd.op)
        OP_BIAS: begin
          if (!seeded_r) bias_r[cmd.axis] <= 24'(rate);
          else if (averaging) bias_r[cmd.axis] <= bsum[24:1];
        end
        OP_WIN: begin
          win_r[idx]        <= corr;
          sum_r[cmd.axis]   <= sum_sel + SUM_W'(corr) - SUM_W'(win_r[idx]);
        end
        OP_RECAL: begin
          bias_r[cmd.axis] <= sat24(32'(bias_r[cmd.axis]) + 32'(wq));
        end
        OP_CLEAR: begin
          pos_r <= '0;
          for (int a = 0; a < 3; a++) begin
            sum_r[a] <= '0;
            att_r[a] <= '0;
          end
          for (int k = 0; k < WIN_DEPTH; k++) win_r[k] <= '0;
          gang_r[0] <= '0;
          gang_r[1] <= '0;
        end
        OP_BIASCNT: begin
          if (!seeded_r) seeded_r <= 1'b1;
          else if (averaging) bias_count_r <= bias_count_r + 8'd1;
          pos_r <= (pos_r == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;
        end
        OP_IACC: begin
          if (active[cmd.axis]) begin
            if (cmd.axis == 2'd2) att_r[2] <= wrap16(32'(att_r[2]) + 32'(dlt));
            else gang_r[cmd.axis[0]] <= sat24(32'(gang_sel) + 32'(dlt));
          end
        end
        OP_BLEND: begin
          if (active[cmd.axis]) att_r[cmd.axis] <= wrap16(32'($signed(bp_r[43:15])));
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  item_r <= in_data;
      OP_SCALE: begin
        mul_r <= 64'(scale_num) * 64'(SCALE_RECIP);
        neg_r <= raw[15];
      end
      OP_BIAS:  rate_r <= rate;
      OP_DIV: begin
        mul_r <= 64'(sum_mag) * 64'(WIN_RECIP);
        neg_r <= sum_sel[SUM_W-1];
      end
      OP_MEAN: begin
        mean_r[cmd.axis] <= (wq_mag > SUM_W'(cfg.outlier_limit)) ? '0 : wq;
      end
      OP_SQA:   sq_r <= a_sq;
      OP_SQB: begin
        rem_r  <= sq_r + b_sq;
        root_r <= '0;
        bit_r  <= 32'h4000_0000;
      end
      OP_SQRT: begin
        if (rem_r >= trial) begin
          rem_r  <= rem_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_CINIT: begin
        cx_r <= $signed({4'd0, root_r[15:0], 8'd0});
        cy_r <= $signed({{3{t_num[16]}}, t_num, 8'd0});
        cz_r <= '0;
        it_r <= '0;
      end
      OP_CORDIC: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + sh_y;
          cy_r <= cy_r - sh_x;
          cz_r <= cz_r + $signed({3'd0, ang});
        end else if (cy_r < 0) begin
          cx_r <= cx_r - sh_y;
          cy_r <= cy_r + sh_x;
          cz_r <= cz_r - $signed({3'd0, ang});
        end
        it_r <= it_r + 1'b1;
      end
      OP_TILT:  acc_r[cmd.tilt] <= 18'(z_rnd) + 18'(off);
      OP_IMUL:  dp_r <= 42'(imul) + 42'sd32768;
      OP_BMUL1: bp_r <= 44'(p1);
      OP_BMUL2: bp_r <= bp_r + 44'(p2) + 44'sd16384;
      OP_OUT: begin
        out_r.roll_angle  <= att_r[0];
        out_r.pitch_angle <= att_r[1];
        out_r.yaw_angle   <= att_r[2];
      end
      default: ;
    endcase
  end

  assign out_data           = out_r;
  assign status.cordic_zero = (cy_r == 28'sd0);

endmodule

// File: rtl/core/icf_checker.sv
// ----------------------------------------------------------------------------
// icf_checker: port-level checks of the attitude filter
// handshake behaviour and single-request sequencing seen at the ports
// ----------------------------------------------------------------------------
module icf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input icf_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input icf_pkg::out_item_t out_data
);
  import icf_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // an accepted request keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one in progress");

  // reset leaves no result on offer
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind imu_attitude_complementary_filter_top icf_checker u_icf_checker (.*);
